### rtl/rgb565_run_length_decoder_top_macros.svh
// Assertion macros shared by the run-length decoder RTL.
`ifndef RGB565_RUN_LENGTH_DECODER_TOP_MACROS_SVH
`define RGB565_RUN_LENGTH_DECODER_TOP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, clocked on clk, disabled while rst_n is low.
`define RLD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, clocked on clk, disabled while rst_n is low.
`define RLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RLD_ASSERT_SAME(lbl, ante, cons, msg)
`define RLD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/rgbrld_pkg.sv
// Types and constants of the RGB565 run-length decoder.
package rgbrld_pkg;

    localparam int INDEX_BITS  = 24;
    localparam int PIXEL_BITS  = 16;
    localparam int LEN_BITS    = 16;
    localparam int COUNT_BITS  = 15;
    localparam int RUN_BIT     = 15;

    localparam logic [INDEX_BITS-1:0] FRAME_PIXELS_RESET = INDEX_BITS'(129600);

    // Decoder phase codes
    localparam logic [1:0] PH_CTRL_LO = 2'd0;
    localparam logic [1:0] PH_CTRL_HI = 2'd1;
    localparam logic [1:0] PH_PIX_LO  = 2'd2;
    localparam logic [1:0] PH_PIX_HI  = 2'd3;

    // Result kinds
    localparam logic KIND_SPAN   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic                  kind;
        logic [PIXEL_BITS-1:0] pixel;
        logic [INDEX_BITS-1:0] start_index;
        logic [LEN_BITS-1:0]   span_length;
        logic                  status;
        logic                  last;
    } result_t;

    // Up to two results per byte: a span, then a status.
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

endpackage

### rtl/rgbrld_if.sv
// Valid/ready channel interfaces for the decoder's byte input and result output.
interface rgbrld_in_if
    import rgbrld_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface rgbrld_out_if
    import rgbrld_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [PIXEL_BITS-1:0] pixel;
    logic [INDEX_BITS-1:0] start_index;
    logic [LEN_BITS-1:0]   span_length;
    logic                  status;
    logic                  last;

    modport source (output valid, output kind, output pixel, output start_index,
                    output span_length, output status, output last, input ready);
    modport sink   (input valid, input kind, input pixel, input start_index,
                    input span_length, input status, input last, output ready);
endinterface

### rtl/rgbrld_core.sv
// Byte input register, frame-size register and the per-byte decode step.
`include "rgb565_run_length_decoder_top_macros.svh"

module rgbrld_core
    import rgbrld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_eos,
    input  logic                  cfg_we,
    input  logic [INDEX_BITS-1:0] cfg_wdata,
    input  logic                  space_ok,
    output push_t                 push
);

    logic                  s_valid_reg;
    logic [7:0]            s_byte_reg;
    logic                  s_eos_reg;
    logic [INDEX_BITS-1:0] frame_reg;

    logic [1:0]            phase_reg, phase_next;
    logic [7:0]            low_reg, low_next;
    logic                  run_reg, run_next;
    logic [LEN_BITS-1:0]   rem_reg, rem_next;
    logic [INDEX_BITS-1:0] wi_reg, wi_next;
    logic                  err_reg, err_next;

    logic                  advance;
    logic                  accept;
    logic [LEN_BITS-1:0]   ctrl;
    logic [LEN_BITS-1:0]   count;
    logic                  too_long;
    logic [LEN_BITS-1:0]   len;
    logic                  span_v;
    result_t               span_res;
    result_t               stat_res;

    assign advance  = s_valid_reg && space_ok;
    assign in_ready = !s_valid_reg || space_ok;
    assign accept   = in_valid && in_ready;

    // decode arithmetic
    assign ctrl     = {s_byte_reg, low_reg};
    assign count    = {1'b0, ctrl[COUNT_BITS-1:0]} + LEN_BITS'(1);
    // count > frame - wi, checked as wi + count > frame one bit wider, only while wi <= frame
    assign too_long = (wi_reg <= frame_reg) &&
                      (({1'b0, wi_reg} + (INDEX_BITS+1)'(count)) > {1'b0, frame_reg});
    assign len      = run_reg ? rem_reg : LEN_BITS'(1);

    always_comb
    begin
        phase_next = phase_reg;
        low_next   = low_reg;
        run_next   = run_reg;
        rem_next   = rem_reg;
        wi_next    = wi_reg;
        err_next   = err_reg;
        span_v     = 1'b0;
        if (!err_reg)
        begin
            case (phase_reg)
                PH_CTRL_LO:
                begin
                    if (wi_reg >= frame_reg)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        low_next   = s_byte_reg;
                        phase_next = PH_CTRL_HI;
                    end
                end
                PH_CTRL_HI:
                begin
                    if (too_long)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        run_next   = ctrl[RUN_BIT];
                        rem_next   = count;
                        phase_next = PH_PIX_LO;
                    end
                end
                PH_PIX_LO:
                begin
                    low_next   = s_byte_reg;
                    phase_next = PH_PIX_HI;
                end
                PH_PIX_HI:
                begin
                    span_v     = 1'b1;
                    wi_next    = wi_reg + INDEX_BITS'(len);
                    rem_next   = rem_reg - len;
                    phase_next = (rem_next == '0) ? PH_CTRL_LO : PH_PIX_LO;
                end
                default:
                begin
                    phase_next = PH_CTRL_LO;
                end
            endcase
        end

        span_res.kind        = KIND_SPAN;
        span_res.pixel       = ctrl;
        span_res.start_index = wi_reg;
        span_res.span_length = len;
        span_res.status      = 1'b0;
        span_res.last        = 1'b0;

        stat_res.kind        = KIND_STATUS;
        stat_res.pixel       = '0;
        stat_res.start_index = wi_next;
        stat_res.span_length = '0;
        stat_res.status      = err_next || (phase_next != PH_CTRL_LO) ||
                               (wi_next != frame_reg);
        stat_res.last        = 1'b1;

        push.push0 = advance && (span_v || s_eos_reg);
        push.push1 = advance && span_v && s_eos_reg;
        push.res0  = span_v ? span_res : stat_res;
        push.res1  = stat_res;

        // end of frame re-arms the decoder
        if (s_eos_reg)
        begin
            phase_next = PH_CTRL_LO;
            low_next   = '0;
            run_next   = 1'b0;
            rem_next   = '0;
            wi_next    = '0;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            frame_reg   <= FRAME_PIXELS_RESET;
            phase_reg   <= PH_CTRL_LO;
            low_reg     <= '0;
            run_reg     <= 1'b0;
            rem_reg     <= '0;
            wi_reg      <= '0;
            err_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                frame_reg <= cfg_wdata;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                low_reg   <= low_next;
                run_reg   <= run_next;
                rem_reg   <= rem_next;
                wi_reg    <= wi_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_byte_reg <= in_byte;
            s_eos_reg  <= in_eos;
        end
    end

    `RLD_ASSERT_NEXT(a_eos_rearms, advance && s_eos_reg,
        (phase_reg == PH_CTRL_LO) && (wi_reg == '0) && !err_reg,
        "decoder not re-armed after end of stream")
    `RLD_ASSERT_NEXT(a_err_sticky, err_reg && !(advance && s_eos_reg), err_reg,
        "error flag cleared before end of stream")
    `RLD_ASSERT_SAME(a_pair_order, push.push1,
        push.push0 && (push.res0.kind == KIND_SPAN) && (push.res1.kind == KIND_STATUS),
        "second result must be a status after a span")

endmodule

### rtl/rgbrld_rfifo.sv
// Four-entry result queue that takes up to two results per cycle.
`include "rgb565_run_length_decoder_top_macros.svh"

module rgbrld_rfifo
    import rgbrld_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    space_ok,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t            entries_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [FIFO_CW-1:0] n_push;
    logic               pop;

    assign space_ok  = count_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_res   = entries_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_push    = FIFO_CW'(push.push0) + FIFO_CW'(push.push1);
    assign count_next = count_reg + n_push - FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_push[FIFO_AW-1:0];
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            entries_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.push1)
        begin
            entries_reg[wr_ptr_reg + FIFO_AW'(1)] <= push.res1;
        end
    end

    `RLD_ASSERT_SAME(a_count_range, 1'b1, count_reg <= FIFO_CW'(FIFO_DEPTH),
        "result queue count out of range")
    `RLD_ASSERT_SAME(a_push_room, push.push0,
        count_reg <= FIFO_CW'(FIFO_DEPTH - 2),
        "result pushed without room for two")
    `RLD_ASSERT_NEXT(a_pop_only, pop && !push.push0,
        count_reg == $past(count_reg) - FIFO_CW'(1),
        "queue count wrong after a pop")

endmodule

### rtl/rgb565_run_length_decoder_top.sv
// Top level of the RGB565 run-length decoder: byte channel in, span/status channel out.
//
// Takes one compressed byte per item and emits pixel spans and one end-of-frame
// status. Each little-endian 16-bit control word gives count = low 15 bits + 1;
// with bit 15 set one pixel follows and becomes a single span of count pixels,
// otherwise count literal pixels follow, each its own span of length 1. The
// byte flagged end_of_stream produces a status item (kind 1, last 1) whose
// start_index is the number of pixels decoded and whose status is 1 on any
// error: a run or literal block past frame_pixels, a byte after the frame is
// full, a truncated word or literal, or a short frame. An error suppresses
// further spans until end of stream; the status item re-arms the decoder.
// Rate: one byte per clock while the queue has room. A byte is held in the input
// register, then its result enters the result queue. Only a byte that both completes
// a pixel and ends the stream yields two items; the four-entry result queue drains
// that pair at one item per cycle while the output is ready, and the input stalls
// only while the queue holds more than two. The user must write frame_pixels
// through cfg_we/cfg_wdata while the decoder is idle; the block does not enforce it.
module rgb565_run_length_decoder_top
    import rgbrld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    rgbrld_in_if.sink             stream,
    rgbrld_out_if.source          result,
    input  logic                  cfg_we,
    input  logic [INDEX_BITS-1:0] cfg_wdata
);

    push_t   push;
    logic    space_ok;
    result_t out_res;

    // decode step: input register, frame state, span/status formation
    rgbrld_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stream.valid),
        .in_ready  (stream.ready),
        .in_byte   (stream.data_byte),
        .in_eos    (stream.end_of_stream),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .space_ok  (space_ok),
        .push      (push)
    );

    // result queue: decouples the output stall from the byte input
    rgbrld_rfifo u_rfifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_res   (out_res)
    );

    assign result.kind        = out_res.kind;
    assign result.pixel       = out_res.pixel;
    assign result.start_index = out_res.start_index;
    assign result.span_length = out_res.span_length;
    assign result.status      = out_res.status;
    assign result.last        = out_res.last;

endmodule
